// ===== rtl/page_framebuffer_draw_update_top_macros.svh =====
// assertion macros for the frame buffer update block checker
`ifndef PAGE_FRAMEBUFFER_DRAW_UPDATE_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_UPDATE_TOP_MACROS_SVH

// property holds at every edge out of reset
`define PFDU_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define PFDU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pfdu_pkg.sv =====
// shared types and constants of the frame buffer update block
package pfdu_pkg;

	localparam logic [7:0] CMD_PAGE   = 8'hb0;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] CMD_COL_LO = 8'h00;

	localparam logic [1:0] EMIT_PAGE   = 2'd0;
	localparam logic [1:0] EMIT_COL_HI = 2'd1;
	localparam logic [1:0] EMIT_COL_LO = 2'd2;
	localparam logic [1:0] EMIT_DATA   = 2'd3;

	typedef struct packed {
		logic       load;
		logic       rd;
		logic       modify;
		logic       init_wr;
		logic [1:0] emit_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic ok;
		logic last;
		logic init_done;
	} ctl_sts_t;

endpackage

// ===== rtl/pfdu_if.sv =====
// handshake channels of the frame buffer update block

interface pfdu_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [5:0] x;
	logic [5:0] y;
	logic [5:0] run_length;
	logic       color;
	modport source (output valid, output op, output x, output y, output run_length,
		output color, input ready);
	modport sink (input valid, input op, input x, input y, input run_length,
		input color, output ready);
endinterface

interface pfdu_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;
	modport source (output valid, output out_byte, output is_data, output last,
		input ready);
	modport sink (input valid, input out_byte, input is_data, input last,
		output ready);
endinterface

interface pfdu_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_offset_high;
	modport source (output valid, output column_offset_high, input ready);
	modport sink (input valid, input column_offset_high, output ready);
endinterface

// ===== rtl/pfdu_ctrl.sv =====
// sequencer for buffer init, read-modify-write of each page byte and word output
module pfdu_ctrl
	import pfdu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t cmd,
	input  ctl_sts_t sts
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_MOD   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] st_q;
	logic [2:0] st_d;
	logic [1:0] em_q;

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_EMIT);

	always_comb begin
		cmd.load     = (st_q == ST_IDLE) && in_valid;
		cmd.rd       = (st_q == ST_RD);
		cmd.modify   = (st_q == ST_MOD);
		cmd.init_wr  = (st_q == ST_INIT);
		cmd.emit_sel = em_q;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_INIT: begin
				if (sts.init_done) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) st_d = ST_CHECK;
			end
			ST_CHECK: begin
				st_d = sts.ok ? ST_RD : ST_IDLE;
			end
			ST_RD: begin
				st_d = ST_MOD;
			end
			ST_MOD: begin
				st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && (em_q == EMIT_DATA)) st_d = sts.last ? ST_IDLE : ST_RD;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
			em_q <= EMIT_PAGE;
		end else begin
			st_q <= st_d;
			// four words per byte, wraps back to the page word
			if ((st_q == ST_EMIT) && out_ready) em_q <= em_q + 2'd1;
		end
	end

endmodule

// ===== rtl/pfdu_dp.sv =====
// frame store, request registers, mask logic and output word select
module pfdu_dp
	import pfdu_pkg::*;
#(
	parameter int WIDTH  = 64,
	parameter int HEIGHT = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_op,
	input  logic [5:0] in_x,
	input  logic [5:0] in_y,
	input  logic [5:0] in_run_length,
	input  logic       in_color,
	input  logic       cfg_valid,
	input  logic [3:0] cfg_column_offset_high,
	input  ctl_cmd_t   cmd,
	output ctl_sts_t   sts,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last
);

	localparam int PAGES = (HEIGHT + 7) / 8;
	localparam int CW    = $clog2(WIDTH);
	localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int AW    = PGW + CW;
	localparam int DEPTH = PAGES * (1 << CW);

	logic [7:0] mem [0:DEPTH-1];

	logic [3:0]    coh_q;
	logic [AW-1:0] ic_q;
	logic [5:0]    x_q;
	logic [6:0]    y_q;
	logic [6:0]    len_q;
	logic          color_q;
	logic          ok_q;
	logic          last_q;
	logic [2:0]    page_q;
	logic [7:0]    new_q;
	logic [7:0]    rdata_s1;

	// request check and bottom clip
	logic [7:0] room8;
	logic [7:0] len8;
	logic [7:0] len_eff8;
	logic       in_ok;

	always_comb begin
		room8    = 8'(HEIGHT) - {2'b00, in_y};
		len8     = {2'b00, in_run_length};
		len_eff8 = in_op ? ((len8 > room8) ? room8 : len8) : 8'd1;
		in_ok    = ({2'b00, in_x} < 8'(WIDTH)) && ({2'b00, in_y} < 8'(HEIGHT))
			&& (len_eff8 != 8'd0);
	end

	// segment of the run that falls in the current page byte
	logic [3:0]    rem;
	logic [3:0]    n;
	logic [3:0]    hi;
	logic [8:0]    m9;
	logic [7:0]    mask;
	logic [7:0]    new_b;
	logic [6:0]    len_next;
	logic [2:0]    pg;
	logic [6:0]    xz;
	logic [AW-1:0] seg_addr;

	always_comb begin
		rem      = 4'd8 - {1'b0, y_q[2:0]};
		n        = (len_q < {3'b000, rem}) ? len_q[3:0] : rem;
		hi       = {1'b0, y_q[2:0]} + n;
		m9       = (9'h0ff << y_q[2:0]) & ~(9'h0ff << hi);
		mask     = m9[7:0];
		new_b    = color_q ? (rdata_s1 | mask) : (rdata_s1 & ~mask);
		len_next = len_q - {3'b000, n};
		pg       = y_q[5:3];
		xz       = {1'b0, x_q};
		seg_addr = {pg[PGW-1:0], xz[CW-1:0]};
	end

	// border pattern for the init sweep
	logic [CW-1:0]  icol;
	logic [PGW-1:0] ipg;
	logic [7:0]     init_b;

	always_comb begin
		icol = ic_q[CW-1:0];
		ipg  = ic_q[AW-1:CW];
		if (icol == CW'(0))              init_b = 8'hff;
		else if (icol == CW'(WIDTH - 1)) init_b = 8'h00;
		else if (ipg == PGW'(0))         init_b = 8'h01;
		else if (ipg == PGW'(PAGES - 1)) init_b = 8'h80;
		else                             init_b = 8'h00;
	end

	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	always_comb begin
		we    = cmd.init_wr || cmd.modify;
		waddr = cmd.init_wr ? ic_q : seg_addr;
		wdata = cmd.init_wr ? init_b : new_b;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.rd) rdata_s1 <= mem[seg_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coh_q <= 4'd2;
			ic_q  <= '0;
			ok_q  <= 1'b0;
		end else begin
			if (cfg_valid) coh_q <= cfg_column_offset_high;
			if (cmd.init_wr) ic_q <= ic_q + AW'(1);
			if (cmd.load) ok_q <= in_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= in_x;
			y_q     <= {1'b0, in_y};
			len_q   <= len_eff8[6:0];
			color_q <= in_color;
		end
		if (cmd.modify) begin
			new_q  <= new_b;
			page_q <= pg;
			last_q <= (len_next == 7'd0);
			len_q  <= len_next;
			y_q    <= y_q + {3'b000, n};
		end
	end

	always_comb begin
		sts.ok        = ok_q;
		sts.last      = last_q;
		sts.init_done = (ic_q == AW'(DEPTH - 1));
	end

	always_comb begin
		out_byte = new_q;
		is_data  = 1'b0;
		last     = 1'b0;
		case (cmd.emit_sel)
			EMIT_PAGE:   out_byte = CMD_PAGE | {5'b00000, page_q};
			EMIT_COL_HI: out_byte = CMD_COL_HI | {4'h0, {2'b00, x_q[5:4]} + coh_q};
			EMIT_COL_LO: out_byte = CMD_COL_LO | {4'h0, x_q[3:0]};
			EMIT_DATA: begin
				out_byte = new_q;
				is_data  = 1'b1;
				last     = last_q;
			end
			default: out_byte = new_q;
		endcase
	end

endmodule

// ===== rtl/page_framebuffer_draw_update_top.sv =====
// Page-organised monochrome frame buffer with display update word stream.
// Each request sets or clears one pixel or a downward vertical run; every touched page
// byte is read, modified and written back, then four words go out: page start, column
// high (plus column_offset_high), column low, and the new data byte, last marked on the
// final one. The request channel is held from acceptance until the last word is taken
// (one read, one write and four output words per byte, sequenced through the single-port
// frame store); a request out of range or with an empty run gives no words. After reset
// the store is filled with the border pattern in a sweep over all
// PAGES * 2**ceil(log2(WIDTH)) addresses (384 at 64 x 48), during which no request is
// taken; configuration writes are always taken.
module page_framebuffer_draw_update_top
	import pfdu_pkg::*;
#(
	parameter int WIDTH  = 64,
	parameter int HEIGHT = 48
) (
	input logic      clk,
	input logic      arst_n,
	pfdu_req_if.sink req,
	pfdu_rsp_if.source rsp,
	pfdu_cfg_if.sink cfg
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	assign cfg.ready = 1'b1;

	pfdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pfdu_dp #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_op                  (req.op),
		.in_x                   (req.x),
		.in_y                   (req.y),
		.in_run_length          (req.run_length),
		.in_color               (req.color),
		.cfg_valid              (cfg.valid),
		.cfg_column_offset_high (cfg.column_offset_high),
		.cmd                    (cmd),
		.sts                    (sts),
		.out_byte               (rsp.out_byte),
		.is_data                (rsp.is_data),
		.last                   (rsp.last)
	);

endmodule

// ===== rtl/pfdu_checker.sv =====
// port-level checks of the frame buffer update block and their bind
`include "page_framebuffer_draw_update_top_macros.svh"

module pfdu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_out_byte,
	input logic       rsp_is_data,
	input logic       rsp_last
);

	// one request at a time: no new request while words go out
	`PFDU_ASSERT(a_excl, !(req_ready && rsp_valid), "request taken while words pending")

	`PFDU_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "ready right after accept")

	`PFDU_ASSERT(a_last_data, !(rsp_valid && rsp_last) || rsp_is_data, "last on command word")

	`PFDU_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_data) && $stable(rsp_last),
		"stalled word changed")

endmodule

bind page_framebuffer_draw_update_top pfdu_checker u_pfdu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_out_byte (rsp.out_byte),
	.rsp_is_data  (rsp.is_data),
	.rsp_last     (rsp.last)
);

// ===== sim/tb_page_framebuffer_draw_update_top.sv =====
// self-checking testbench for the page frame buffer draw and update block
module tb_page_framebuffer_draw_update_top
	import pfdu_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH = 64;
	localparam int HEIGHT = 48;
	localparam int PAGES = (HEIGHT + 7) / 8;
	localparam int DIR_N = 21;
	localparam int N_PHASES = 5;
	localparam int PHASE_ITEMS = 28;
	localparam int SETTLE = 24;
	localparam int HOLD_CYCLES = 600;
	localparam int LIMIT = 1000000;

	typedef struct packed {
		logic       op;
		logic [5:0] x;
		logic [5:0] y;
		logic [5:0] run_length;
		logic       color;
	} draw_req_t;

	typedef struct packed {
		draw_req_t   req;
		logic        typed;
		logic [2:0]  n_words;
		logic [31:0] words;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} disp_word_t;

	logic clk;
	logic arst_n;

	pfdu_req_if req_ch ();
	pfdu_rsp_if rsp_ch ();
	pfdu_cfg_if cfg_ch ();

	page_framebuffer_draw_update_top #(
		.WIDTH (WIDTH),
		.HEIGHT(HEIGHT)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// predictor copy of the frame store and offset register
	logic [7:0] shadow_fb [PAGES * WIDTH];
	logic [3:0] shadow_col_off;
	disp_word_t pending_words[$];
	dir_row_t dir_rows [DIR_N];

	int err_count;
	int word_count;
	int req_count;
	int cycle_count;
	int offsets_seen;
	logic tx_calm;
	logic rx_calm;
	logic hold_go;
	logic hold_on;
	int rdy_wait;
	disp_word_t chk_want;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 40);
	endfunction

	function automatic dir_row_t mk_row(input logic op, input int x, input int y,
		input int len, input logic color, input logic typed, input int n,
		input logic [31:0] words);
		dir_row_t r;
		r.req.op = op;
		r.req.x = 6'(x);
		r.req.y = 6'(y);
		r.req.run_length = 6'(len);
		r.req.color = color;
		r.typed = typed;
		r.n_words = 3'(n);
		r.words = words;
		return r;
	endfunction

	function automatic void push_word(input logic [7:0] b, input logic is_data,
		input logic last);
		disp_word_t w;
		w.out_byte = b;
		w.is_data = is_data;
		w.last = last;
		pending_words.push_back(w);
	endfunction

	function automatic void reset_shadow();
		int p;
		int c;
		logic [7:0] d;
		for (p = 0; p < PAGES; p++) begin
			for (c = 0; c < WIDTH; c++) begin
				if (c == 0)
					d = 8'hff;
				else if (c == WIDTH - 1)
					d = 8'h00;
				else if (p == 0)
					d = 8'h01;
				else if (p == PAGES - 1)
					d = 8'h80;
				else
					d = 8'h00;
				shadow_fb[p * WIDTH + c] = d;
			end
		end
		shadow_col_off = 4'd2;
	endfunction

	// read-modify-write one page byte, then queue its four words when emit is set
	function automatic void touch_byte(input int page, input logic [5:0] x,
		input logic [7:0] mask, input logic color, input logic last, input logic emit);
		int idx;
		logic [7:0] v;
		idx = page * WIDTH + x;
		v = shadow_fb[idx];
		v = color ? (v | mask) : (v & ~mask);
		shadow_fb[idx] = v;
		if (emit) begin
			push_word(CMD_PAGE | {5'd0, 3'(page)}, 1'b0, 1'b0);
			push_word(CMD_COL_HI | {4'd0, 4'({2'b00, x[5:4]} + shadow_col_off)}, 1'b0, 1'b0);
			push_word(CMD_COL_LO | {4'd0, x[3:0]}, 1'b0, 1'b0);
			push_word(v, 1'b1, last);
		end
	endfunction

	function automatic void draw_and_predict(input draw_req_t d, input logic emit);
		int row;
		int remaining;
		int bit_pos;
		int n;
		logic [7:0] mask;
		if (int'(d.x) >= WIDTH || int'(d.y) >= HEIGHT)
			return;
		if (!d.op) begin
			touch_byte(d.y / 8, d.x, 8'(1 << (d.y % 8)), d.color, 1'b1, emit);
			return;
		end
		row = d.y;
		remaining = d.run_length;
		if (remaining > HEIGHT - row)
			remaining = HEIGHT - row;
		while (remaining != 0) begin
			bit_pos = row % 8;
			n = 8 - bit_pos;
			if (remaining < n)
				n = remaining;
			mask = 8'(((1 << n) - 1) << bit_pos);
			remaining -= n;
			touch_byte(row / 8, d.x, mask, d.color, remaining == 0, emit);
			row += n;
		end
	endfunction

	function automatic draw_req_t random_draw();
		draw_req_t d;
		int r;
		d.op = ($urandom_range(0, 99) < 60);
		d.x = 6'($urandom_range(0, 63));
		d.y = ($urandom_range(0, 99) < 10) ? 6'($urandom_range(48, 63))
			: 6'($urandom_range(0, 47));
		r = $urandom_range(0, 99);
		if (r < 8)
			d.run_length = 6'd0;
		else if (r < 70)
			d.run_length = 6'($urandom_range(1, 12));
		else if (r < 90)
			d.run_length = 6'($urandom_range(13, 48));
		else
			d.run_length = 6'($urandom_range(49, 63));
		d.color = 1'($urandom_range(0, 1));
		return d;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at word %0d: %s got %0h want %0h", word_count, what, got, want);
		err_count++;
	endtask

	task automatic send_draw(input draw_req_t d, input logic typed, input logic [2:0] n_words,
		input logic [31:0] words);
		int gap;
		int i;
		gap = tx_calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= d.op;
		req_ch.x <= d.x;
		req_ch.y <= d.y;
		req_ch.run_length <= d.run_length;
		req_ch.color <= d.color;
		do @(posedge clk); while (!req_ch.ready);
		req_count++;
		draw_and_predict(d, !typed);
		// typed rows carry their words written out by hand
		if (typed) begin
			for (i = 0; i < n_words; i++)
				push_word(words[31 - 8 * i -: 8], i == 3, i == 3);
		end
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_col_offset(input logic [3:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.column_offset_high <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		shadow_col_off = v;
		offsets_seen++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// response side ready pattern
	always @(negedge clk) begin
		if (hold_on) begin
			rsp_ch.ready <= 1'b0;
		end else if (rdy_wait > 0) begin
			rsp_ch.ready <= 1'b0;
			rdy_wait <= rdy_wait - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			rdy_wait <= rx_calm ? 0 : pick_gap();
		end
	end

	// long stall of the receiver so the block backs up into the request side
	initial begin
		hold_on = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			word_count++;
			if (pending_words.size() == 0) begin
				report_mismatch("word with nothing pending", rsp_ch.out_byte, 0);
			end else begin
				chk_want = pending_words.pop_front();
				if (rsp_ch.out_byte !== chk_want.out_byte)
					report_mismatch("out_byte", rsp_ch.out_byte, chk_want.out_byte);
				if (rsp_ch.is_data !== chk_want.is_data)
					report_mismatch("is_data", rsp_ch.is_data, chk_want.is_data);
				if (rsp_ch.last !== chk_want.last)
					report_mismatch("last", rsp_ch.last, chk_want.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("timeout with %0d words still pending", pending_words.size());
			$display("page_framebuffer_draw_update_top verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		int p;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = 1'b0;
		req_ch.x = 6'd0;
		req_ch.y = 6'd0;
		req_ch.run_length = 6'd0;
		req_ch.color = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.column_offset_high = 4'd0;
		err_count = 0;
		word_count = 0;
		req_count = 0;
		cycle_count = 0;
		offsets_seen = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_go = 1'b0;
		rdy_wait = 0;
		reset_shadow();

		// single pixels on reset contents and out of range or empty requests
		dir_rows[0]  = mk_row(1'b0, 0, 0, 0, 1'b0, 1'b1, 4, 32'hb0_12_00_fe);
		dir_rows[1]  = mk_row(1'b0, 63, 47, 0, 1'b1, 1'b1, 4, 32'hb5_15_0f_80);
		dir_rows[2]  = mk_row(1'b0, 1, 0, 0, 1'b0, 1'b1, 4, 32'hb0_12_01_00);
		dir_rows[3]  = mk_row(1'b0, 0, 48, 0, 1'b1, 1'b1, 0, 32'h0);
		dir_rows[4]  = mk_row(1'b1, 20, 63, 5, 1'b1, 1'b1, 0, 32'h0);
		dir_rows[5]  = mk_row(1'b1, 30, 10, 0, 1'b1, 1'b1, 0, 32'h0);
		dir_rows[6]  = mk_row(1'b0, 62, 47, 63, 1'b0, 1'b1, 4, 32'hb5_15_0e_00);
		// runs: full column, clipped, within a byte, across pages; also single pixels
		dir_rows[7]  = mk_row(1'b1, 5, 0, 48, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[8]  = mk_row(1'b1, 5, 0, 63, 1'b0, 1'b0, 0, 32'h0);
		dir_rows[9]  = mk_row(1'b1, 10, 40, 20, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[10] = mk_row(1'b1, 17, 3, 2, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[11] = mk_row(1'b1, 33, 6, 4, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[12] = mk_row(1'b1, 63, 47, 1, 1'b0, 1'b0, 0, 32'h0);
		dir_rows[13] = mk_row(1'b1, 48, 1, 46, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[14] = mk_row(1'b0, 42, 21, 0, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[15] = mk_row(1'b0, 42, 21, 0, 1'b0, 1'b0, 0, 32'h0);
		dir_rows[16] = mk_row(1'b1, 0, 0, 1, 1'b0, 1'b0, 0, 32'h0);
		dir_rows[17] = mk_row(1'b0, 31, 63, 0, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[18] = mk_row(1'b1, 12, 8, 8, 1'b1, 1'b0, 0, 32'h0);
		dir_rows[19] = mk_row(1'b1, 12, 8, 9, 1'b0, 1'b0, 0, 32'h0);
		dir_rows[20] = mk_row(1'b0, 15, 15, 32, 1'b1, 1'b0, 0, 32'h0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed part runs on the reset value of the offset register
		for (i = 0; i < DIR_N; i++)
			send_draw(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].n_words,
				dir_rows[i].words);
		drain_and_settle();

		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: write_col_offset(4'd15);
				1: write_col_offset(4'd0);
				2: write_col_offset(4'($urandom_range(3, 13)));
				3: write_col_offset(4'd1);
				default: write_col_offset(4'd14);
			endcase
			tx_calm <= (p == 1) || (p == 3);
			rx_calm <= (p == 3);
			if (p == 1)
				hold_go = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_draw(random_draw(), 1'b0, 3'd0, 32'h0);
			drain_and_settle();
		end

		$display("ran %0d draw requests (%0d directed) giving %0d display words",
			req_count, DIR_N, word_count);
		$display("offset register written %0d times, one long receiver stall included",
			offsets_seen);
		if (err_count == 0)
			$display("page_framebuffer_draw_update_top verification clean");
		else
			$display("page_framebuffer_draw_update_top verification failed");
		$finish;
	end

endmodule
